/* design/ilb_pkg.sv */
// Package for the indexed list buffer: action and status codes, port field widths
// and the result word type passed from the sequencer to the output register.
// No dependencies.
`default_nettype none

package ilb_pkg;

   localparam int ACTION_W   = 3;
   localparam int POSITION_W = 7;
   localparam int ITEM_W     = 32;
   localparam int COUNT_W    = 7;
   localparam int STATUS_W   = 2;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam action_type ACT_APPEND   = 3'd0;
   localparam action_type ACT_INSERT   = 3'd1;
   localparam action_type ACT_POP      = 3'd2;
   localparam action_type ACT_WITHDRAW = 3'd3;
   localparam action_type ACT_READ     = 3'd4;
   localparam action_type ACT_REMOVE   = 3'd5;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;
   localparam status_type ST_RANGE = 2'd3;

   typedef struct packed {
      logic [ITEM_W-1:0]  item;
      logic [COUNT_W-1:0] count;
      status_type         status;
   } rsp_word_type;

endpackage

`default_nettype wire

/* design/ilb_mem.sv */
// Entry store of the indexed list buffer: one write port and one read port,
// read data registered. No dependencies.
`default_nettype none

module ilb_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/ilb_seq.sv */
// Sequencer of the indexed list buffer: decodes a request, checks it against the
// count and shifts entries one a cycle through ilb_mem. Depends on ilb_pkg.
`default_nettype none

module ilb_seq #(
   parameter int CAPACITY  = 64,
   parameter int ITEM_BITS = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire ilb_pkg::action_type              req_action,
   input  wire logic [ilb_pkg::POSITION_W-1:0]   req_position,
   input  wire logic [ilb_pkg::ITEM_W-1:0]       req_item_in,
   output logic                                  done_valid,
   output ilb_pkg::rsp_word_type                 done_word,
   input  wire logic                             done_take,
   output logic                                  mem_rd_en,
   output logic      [$clog2(CAPACITY)-1:0]      mem_rd_addr,
   input  wire logic [ITEM_BITS-1:0]             mem_rd_data,
   output logic                                  mem_wr_en,
   output logic      [$clog2(CAPACITY)-1:0]      mem_wr_addr,
   output logic      [ITEM_BITS-1:0]             mem_wr_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > ilb_pkg::POSITION_W) ? CW : ilb_pkg::POSITION_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_INS  = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_REM  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]                  state_ff, state_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [CW-1:0]               ptr_ff, ptr_in;
   logic [CW-1:0]               idx_ff, idx_in;
   ilb_pkg::action_type         act_ff, act_in;
   logic [ITEM_BITS-1:0]        new_item_ff, new_item_in;
   logic                        pend_ff, pend_in;
   logic [AW-1:0]               dst_ff, dst_in;
   logic                        cap_ff, cap_in;
   logic [ilb_pkg::ITEM_W-1:0]  res_ff, res_in;
   ilb_pkg::status_type         status_ff, status_in;

   logic [PW-1:0]               pos_w;
   logic [PW-1:0]               cnt_w;
   logic                        full;
   logic                        empty;
   ilb_pkg::status_type         dec_status;
   logic                        dec_ins;
   logic                        dec_rd;
   logic [CW-1:0]               dec_idx;
   logic [ilb_pkg::ITEM_W-1:0]  res_now;

   assign pos_w   = PW'(req_position);
   assign cnt_w   = PW'(cnt_ff);
   assign full    = (cnt_ff == CW'(CAPACITY));
   assign empty   = (cnt_ff == '0);
   assign res_now = cap_ff ? ilb_pkg::ITEM_W'(mem_rd_data) : res_ff;

   always_comb begin
      dec_status = ilb_pkg::ST_OK;
      dec_ins    = 1'b0;
      dec_rd     = 1'b0;
      dec_idx    = '0;
      unique case (req_action)
         ilb_pkg::ACT_APPEND: begin
            dec_idx = cnt_ff;
            if (full) begin
               dec_status = ilb_pkg::ST_FULL;
            end else begin
               dec_ins = 1'b1;
            end
         end
         ilb_pkg::ACT_INSERT: begin
            dec_idx = CW'(req_position);
            if (pos_w > cnt_w) begin
               dec_status = ilb_pkg::ST_RANGE;
            end else if (full) begin
               dec_status = ilb_pkg::ST_FULL;
            end else begin
               dec_ins = 1'b1;
            end
         end
         ilb_pkg::ACT_POP: begin
            dec_idx = cnt_ff - 1'b1;
            if (empty) begin
               dec_status = ilb_pkg::ST_EMPTY;
            end else begin
               dec_rd = 1'b1;
            end
         end
         ilb_pkg::ACT_WITHDRAW: begin
            if (empty) begin
               dec_status = ilb_pkg::ST_EMPTY;
            end else begin
               dec_rd = 1'b1;
            end
         end
         ilb_pkg::ACT_READ, ilb_pkg::ACT_REMOVE: begin
            dec_idx = CW'(req_position);
            if (empty) begin
               dec_status = ilb_pkg::ST_EMPTY;
            end else if (pos_w >= cnt_w) begin
               dec_status = ilb_pkg::ST_RANGE;
            end else begin
               dec_rd = 1'b1;
            end
         end
         default: begin
            dec_status = ilb_pkg::ST_OK;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      ptr_in      = ptr_ff;
      idx_in      = idx_ff;
      act_in      = act_ff;
      new_item_in = new_item_ff;
      pend_in     = 1'b0;
      dst_in      = dst_ff;
      cap_in      = 1'b0;
      res_in      = res_now;
      status_in   = status_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = AW'(ptr_ff);
      mem_wr_en   = pend_ff;
      mem_wr_addr = dst_ff;
      mem_wr_data = mem_rd_data;
      done_valid  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in      = req_action;
               new_item_in = ITEM_BITS'(req_item_in);
               idx_in      = dec_idx;
               status_in   = dec_status;
               res_in      = '0;
               if (dec_ins) begin
                  ptr_in   = cnt_ff;
                  state_in = S_INS;
               end else if (dec_rd) begin
                  ptr_in   = dec_idx;
                  state_in = S_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_INS: begin
            if (ptr_ff != idx_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(ptr_ff - 1'b1);
               pend_in     = 1'b1;
               dst_in      = AW'(ptr_ff);
               ptr_in      = ptr_ff - 1'b1;
            end else if (!pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = AW'(idx_ff);
               mem_wr_data = new_item_ff;
               cnt_in      = cnt_ff + 1'b1;
               state_in    = S_DONE;
            end
         end
         S_RD: begin
            mem_rd_en = 1'b1;
            cap_in    = (act_ff != ilb_pkg::ACT_REMOVE);
            ptr_in    = ptr_ff + 1'b1;
            state_in  = (act_ff == ilb_pkg::ACT_READ) ? S_DONE : S_REM;
         end
         S_REM: begin
            if (ptr_ff != cnt_ff) begin
               mem_rd_en = 1'b1;
               pend_in   = 1'b1;
               dst_in    = AW'(ptr_ff - 1'b1);
               ptr_in    = ptr_ff + 1'b1;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            done_valid = 1'b1;
            if (done_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign done_word.item   = res_now;
   assign done_word.count  = ilb_pkg::COUNT_W'(cnt_ff);
   assign done_word.status = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
         cap_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         cap_ff   <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      idx_ff      <= idx_in;
      act_ff      <= act_in;
      new_item_ff <= new_item_in;
      dst_ff      <= dst_in;
      res_ff      <= res_in;
      status_ff   <= status_in;
   end

endmodule

`default_nettype wire

/* design/indexed_list_buffer_top.sv */
// Top level of the indexed list buffer: sequencer, entry store and result register.
// Depends on ilb_pkg, ilb_mem and ilb_seq.
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   req     | req_valid req_stall req_action req_position   | in
//           | req_item_in                                   |
//   rsp     | rsp_valid rsp_stall rsp_item_out rsp_count_now | out
//           | rsp_status                                    |
//
// One word at a time. A failed or ignored request goes straight to the result; append and
// insert move each entry from the tail down to the position up by one and then write the
// new item; read reads one entry; pop, withdraw and remove read the entry at the index
// (pop at count - 1, withdraw at 0) and move those above it down, one entry move per cycle.
// Reset clears the count, the state and the response valid, not the entries; entries are
// never read before being written. A waiting result sits in the output register while the next word is taken.
`default_nettype none

module indexed_list_buffer_top #(
   parameter int CAPACITY  = 64,
   parameter int ITEM_BITS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire ilb_pkg::action_type             req_action,
   input  wire logic [ilb_pkg::POSITION_W-1:0]  req_position,
   input  wire logic [ilb_pkg::ITEM_W-1:0]      req_item_in,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [ilb_pkg::ITEM_W-1:0]      rsp_item_out,
   output logic      [ilb_pkg::COUNT_W-1:0]     rsp_count_now,
   output ilb_pkg::status_type                  rsp_status
);

   localparam int AW = $clog2(CAPACITY);

   logic                  done_valid;
   logic                  done_take;
   ilb_pkg::rsp_word_type done_word;
   logic                  mem_rd_en;
   logic [AW-1:0]         mem_rd_addr;
   logic [ITEM_BITS-1:0]  mem_rd_data;
   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [ITEM_BITS-1:0]  mem_wr_data;

   logic                  rsp_valid_ff, rsp_valid_in;
   ilb_pkg::rsp_word_type rsp_word_ff;

   ilb_seq #(
      .CAPACITY  (CAPACITY),
      .ITEM_BITS (ITEM_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_position (req_position),
      .req_item_in  (req_item_in),
      .done_valid   (done_valid),
      .done_word    (done_word),
      .done_take    (done_take),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data)
   );

   ilb_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (ITEM_BITS)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   assign done_take    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = done_valid || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_valid && done_take) begin
         rsp_word_ff <= done_word;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_item_out  = rsp_word_ff.item;
   assign rsp_count_now = rsp_word_ff.count;
   assign rsp_status    = rsp_word_ff.status;

endmodule

`default_nettype wire

/* dv/tb_indexed_list_buffer_top.sv */
// Self-checking testbench for indexed_list_buffer_top: drives list actions with random idling
// on both channels and compares every response word with a built-in list predictor.
// Depends on ilb_pkg and the RTL under design/.
`default_nettype none

module tb_indexed_list_buffer_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ilb_pkg::*;

   localparam int          CAP          = 64;
   localparam int          WORDS        = 1450;
   localparam int          QUIET_TAIL   = 150;
   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam int          SETTLE       = 100;
   localparam action_type  ACT_SPARE_LO = 3'd6;
   localparam action_type  ACT_SPARE_HI = 3'd7;

   typedef enum {GROW, SHRINK, CHURN} trend_type;

   class list_scoreboard_type;
      logic [ITEM_W-1:0] store [CAP];
      int unsigned       held;
      int unsigned       peak;
      rsp_word_type      due_q [$];
      int unsigned       errors;
      int unsigned       checked;
      int unsigned       taken;
      int unsigned       status_seen [4];

      function void open_gap(int unsigned idx, logic [ITEM_W-1:0] val);
         for (int unsigned i = held; i > idx; i--) store[i] = store[i-1];
         store[idx] = val;
         held++;
         if (held > peak) peak = held;
      endfunction

      function logic [ITEM_W-1:0] close_gap(int unsigned idx);
         logic [ITEM_W-1:0] v;
         v = store[idx];
         for (int unsigned i = idx; i + 1 < held; i++) store[i] = store[i+1];
         held--;
         return v;
      endfunction

      function void note_request(action_type act, logic [POSITION_W-1:0] pos,
                                 logic [ITEM_W-1:0] val);
         rsp_word_type w;
         w.item   = '0;
         w.status = ST_OK;
         case (act)
            ACT_APPEND: begin
               if (held >= CAP) w.status = ST_FULL;
               else open_gap(held, val);
            end
            ACT_INSERT: begin
               if (pos > held) w.status = ST_RANGE;
               else if (held >= CAP) w.status = ST_FULL;
               else open_gap(pos, val);
            end
            ACT_POP: begin
               if (held == 0) w.status = ST_EMPTY;
               else w.item = close_gap(held - 1);
            end
            ACT_WITHDRAW: begin
               if (held == 0) w.status = ST_EMPTY;
               else w.item = close_gap(0);
            end
            ACT_READ: begin
               if (held == 0) w.status = ST_EMPTY;
               else if (pos >= held) w.status = ST_RANGE;
               else w.item = store[pos];
            end
            ACT_REMOVE: begin
               if (held == 0) w.status = ST_EMPTY;
               else if (pos >= held) w.status = ST_RANGE;
               else void'(close_gap(pos));
            end
            default: ;
         endcase
         w.count = COUNT_W'(held);
         status_seen[w.status]++;
         taken++;
         due_q.push_back(w);
      endfunction

      function void check_response(logic [ITEM_W-1:0] item, logic [COUNT_W-1:0] count,
                                   status_type status);
         rsp_word_type w;
         if (due_q.size() == 0) begin
            $display("%0t: response word with nothing expected (item %h count %0d status %0d)",
                     $realtime, item, count, status);
            errors++;
            return;
         end
         w = due_q.pop_front();
         checked++;
         if (item !== w.item) begin
            $display("%0t: item mismatch: expected %h, got %h", $realtime, w.item, item);
            errors++;
         end
         if (count !== w.count) begin
            $display("%0t: count mismatch: expected %0d, got %0d", $realtime, w.count, count);
            errors++;
         end
         if (status !== w.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d", $realtime, w.status, status);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return due_q.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   action_type            req_action;
   logic [POSITION_W-1:0] req_position;
   logic [ITEM_W-1:0]     req_item_in;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [ITEM_W-1:0]     rsp_item_out;
   logic [COUNT_W-1:0]    rsp_count_now;
   status_type            rsp_status;

   list_scoreboard_type   sb = new();
   int unsigned           idle_pct;

   indexed_list_buffer_top #(.CAPACITY(CAP), .ITEM_BITS(ITEM_W)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_position  (req_position),
      .req_item_in   (req_item_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_item_out  (rsp_item_out),
      .rsp_count_now (rsp_count_now),
      .rsp_status    (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d words still expected", CYCLE_LIMIT, sb.pending());
      $display("FAIL");
      $finish;
   end

   // response stall in random bursts
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         sb.check_response(rsp_item_out, rsp_count_now, rsp_status);
   end

   task automatic send_word(input action_type act, input logic [POSITION_W-1:0] pos,
                            input logic [ITEM_W-1:0] val);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_position <= pos;
      req_item_in  <= val;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_request(act, pos, val);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [ITEM_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [POSITION_W-1:0] pick_position(input action_type act);
      int unsigned lim;
      if ($urandom_range(0, 9) == 0)
         return POSITION_W'($urandom_range(0, (1 << POSITION_W) - 1));
      if (act == ACT_INSERT) lim = sb.held;
      else lim = (sb.held == 0) ? 0 : sb.held - 1;
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return POSITION_W'(lim);
         default: return POSITION_W'($urandom_range(0, lim));
      endcase
   endfunction

   function automatic action_type pick_action(input trend_type trend);
      int unsigned r;
      r = $urandom_range(0, 99);
      case (trend)
         GROW: begin
            if (r < 45) return ACT_APPEND;
            if (r < 85) return ACT_INSERT;
            if (r < 92) return ACT_READ;
         end
         SHRINK: begin
            if (r < 25) return ACT_POP;
            if (r < 50) return ACT_WITHDRAW;
            if (r < 80) return ACT_REMOVE;
            if (r < 92) return ACT_READ;
         end
         default: begin
            if (r < 15) return ACT_APPEND;
            if (r < 35) return ACT_INSERT;
            if (r < 50) return ACT_POP;
            if (r < 60) return ACT_WITHDRAW;
            if (r < 78) return ACT_READ;
            if (r < 95) return ACT_REMOVE;
         end
      endcase
      return action_type'($urandom_range(0, (1 << ACTION_W) - 1));
   endfunction

   initial begin
      int unsigned sent;
      int unsigned run_len;
      int unsigned phase;
      trend_type   trend;
      action_type  act;

      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_action   <= ACT_APPEND;
      req_position <= '0;
      req_item_in  <= '0;
      idle_pct      = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // edge cases on an empty and a short list
      send_word(ACT_POP,      7'd0,   32'h1111_1111);
      send_word(ACT_WITHDRAW, 7'd0,   32'h2222_2222);
      send_word(ACT_READ,     7'd0,   32'h0);
      send_word(ACT_REMOVE,   7'd127, 32'h0);
      send_word(ACT_INSERT,   7'd1,   32'hDEAD_BEEF);
      send_word(ACT_INSERT,   7'd0,   32'hFFFF_FFFF);
      send_word(ACT_APPEND,   7'd127, 32'h0000_0000);
      send_word(ACT_APPEND,   7'd64,  32'h8000_0001);
      send_word(ACT_INSERT,   7'd1,   32'hA5A5_A5A5);
      send_word(ACT_READ,     7'd4,   32'h0);
      send_word(ACT_READ,     7'd3,   32'h0);
      send_word(ACT_READ,     7'd127, 32'h0);
      send_word(ACT_REMOVE,   7'd4,   32'h0);
      send_word(ACT_REMOVE,   7'd1,   32'h5A5A_5A5A);
      send_word(ACT_INSERT,   7'd3,   32'h7FFF_FFFE);
      send_word(ACT_WITHDRAW, 7'd0,   32'h0);
      send_word(ACT_POP,      7'd0,   32'h0);
      send_word(ACT_SPARE_LO, 7'd0,   32'hFFFF_FFFF);
      send_word(ACT_SPARE_HI, 7'd127, 32'h0);
      send_word(ACT_INSERT,   7'd100, 32'h1234_5678);
      send_word(ACT_READ,     7'd0,   32'h0);
      hold_until_drained();

      sent  = 0;
      phase = 0;
      while (sent < WORDS) begin
         case (phase)
            0:       begin trend = GROW;   run_len = 130; end
            1:       begin trend = SHRINK; run_len = 130; end
            default: begin
               trend   = trend_type'($urandom_range(0, 2));
               run_len = $urandom_range(40, 120);
            end
         endcase
         if (sent + QUIET_TAIL >= WORDS) idle_pct = 0;
         else case ($urandom_range(0, 2))
            0:       idle_pct = 0;
            1:       idle_pct = 15;
            default: idle_pct = 35;
         endcase
         for (int unsigned k = 0; k < run_len && sent < WORDS; k++) begin
            act = pick_action(trend);
            send_word(act, pick_position(act), pick_value());
            if (act <= ACT_REMOVE) sent++;
            if (sent + QUIET_TAIL == WORDS) idle_pct = 0;
         end
         if ($urandom_range(0, 2) == 0) hold_until_drained();
         phase++;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("%0d request words sent, %0d responses checked, peak list length %0d",
               sb.taken, sb.checked, sb.peak);
      $display("status ok/full/empty/range seen: %0d/%0d/%0d/%0d",
               sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
               sb.status_seen[ST_EMPTY], sb.status_seen[ST_RANGE]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* indexed_list_buffer_top.f */
design/ilb_pkg.sv
design/ilb_mem.sv
design/ilb_seq.sv
design/indexed_list_buffer_top.sv
dv/tb_indexed_list_buffer_top.sv
